// ----- rtl/aes_dec_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aes_dec_pkg
// shared tables, types and helper functions for the aes-128 inverse cipher
// ----------------------------------------------------------------------------
package aes_dec_pkg;

    localparam int unsigned NUM_ROUNDS = 10;

    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;
    localparam logic [63:0] KEY_HIGH_RESET = 64'h3031323334353637;
    localparam logic [63:0] KEY_LOW_RESET  = 64'h3839616263646566;

    typedef logic [127:0] blk_t;
    typedef blk_t rkeys_t [NUM_ROUNDS+1];

    function automatic logic [7:0] fwd_sbox(input logic [7:0] x);
        logic [7:0] r;
        case (x)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // inverse box built from the forward table; a constant table after synthesis
    function automatic logic [7:0] inv_sub_byte(input logic [7:0] y);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 256; i++) begin
            if (fwd_sbox(8'(i)) == y) begin
                r = 8'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {fwd_sbox(w[31:24]), fwd_sbox(w[23:16]), fwd_sbox(w[15:8]), fwd_sbox(w[7:0])};
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] r);
        logic [7:0] v;
        case (r)
            4'd0: v = 8'h01; 4'd1: v = 8'h02; 4'd2: v = 8'h04; 4'd3: v = 8'h08;
            4'd4: v = 8'h10; 4'd5: v = 8'h20; 4'd6: v = 8'h40; 4'd7: v = 8'h80;
            4'd8: v = 8'h1b; 4'd9: v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // one key schedule step: round key r from round key r-1 (rc index r-1)
    function automatic blk_t next_round_key(input blk_t k, input logic [3:0] ri);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
        t  = sub_word({w3[23:0], w3[31:24]}) ^ {rcon(ri), 24'h0};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage
`default_nettype wire

// ----- rtl/aes128_block_decrypt.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aes128_block_decrypt
// aes-128 ecb inverse cipher, fully unrolled round pipeline
// ----------------------------------------------------------------------------
// one ciphertext block per cycle enters the pipeline unless back pressure or
// key expansion holds it; the plaintext passes the initial key add stage and
// then ten registered rounds, each round one stage. the whole pipeline
// advances whenever the output register is empty or its transaction is taken,
// so the block keeps one transaction per cycle under no back pressure and no
// key expansion. the key schedule runs after reset or after a key write;
// input is held off during that time. key writes are to be issued while the
// pipeline is empty. tdata packs cipher_high in bits [63:0] and cipher_low in
// [127:64]; the result side packs plain_high and plain_low the same way.
module aes128_block_decrypt (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // [63:0] cipher_high, [127:64] cipher_low
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata,   // [63:0] plain_high, [127:64] plain_low
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [0:0]   cfg_index,
    input  wire logic [63:0]  cfg_data
);
    import aes_dec_pkg::*;

    rkeys_t round_keys;
    logic   ks_busy;
    logic   adv;
    logic   v   [NUM_ROUNDS+1];
    blk_t   d   [NUM_ROUNDS+1];
    logic   v0_reg;
    blk_t   d0_reg;

    assign cfg_ready = 1'b1;

    aes_dec_key_sched u_ks (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid),
        .cfg_sel   (cfg_index[0]),
        .cfg_data  (cfg_data),
        .busy      (ks_busy),
        .round_keys(round_keys)
    );

    // whole pipeline moves together; stalls only when the last stage is held
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv && !ks_busy;

    // stage zero: initial add with round key 10
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= s_tvalid && s_tready;
        end
        if (adv) begin
            d0_reg <= {s_tdata[63:0], s_tdata[127:64]} ^ round_keys[NUM_ROUNDS];
        end
    end

    assign v[0] = v0_reg;
    assign d[0] = d0_reg;

    for (genvar g = 1; g <= NUM_ROUNDS; g++) begin : g_round
        aes_dec_round #(.LAST(g == NUM_ROUNDS)) u_round (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (adv),
            .in_valid (v[g-1]),
            .in_data  (d[g-1]),
            .round_key(round_keys[NUM_ROUNDS-g]),
            .out_valid(v[g]),
            .out_data (d[g])
        );
    end

    assign m_tvalid = v[NUM_ROUNDS];
    assign m_tdata  = {d[NUM_ROUNDS][63:0], d[NUM_ROUNDS][127:64]};

`ifndef NO_ASSERTIONS
    // a held result must not change while the pipeline is frozen
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under back pressure");
    // no input is taken while round keys are being rebuilt
    a_ks: assert property (@(posedge aclk) disable iff (!aresetn)
        ks_busy |-> !s_tready)
        else $error("input accepted during key expansion");
    // a stage zero entry follows an accepted transaction
    a_v0: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> v0_reg)
        else $error("accepted transaction lost at stage zero");
`endif

endmodule
`default_nettype wire

// ----- rtl/aes_dec_round.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aes_dec_round
// one registered inverse round: shift, sub, add key, optional inverse mix
// ----------------------------------------------------------------------------
module aes_dec_round #(
    parameter bit LAST = 1'b0
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire aes_dec_pkg::blk_t   in_data,
    input  wire aes_dec_pkg::blk_t   round_key,
    output logic                     out_valid,
    output aes_dec_pkg::blk_t        out_data
);
    import aes_dec_pkg::*;

    logic [7:0] s  [16];
    logic [7:0] t  [16];
    logic [7:0] m  [16];
    blk_t       data_next;
    blk_t       data_reg;
    logic       valid_reg;

    function automatic logic [7:0] mul(input logic [7:0] x, input logic [3:0] y);
        logic [7:0] x2, x4, x8;
        x2 = xtime(x); x4 = xtime(x2); x8 = xtime(x4);
        return (y[0] ? x : 8'h0) ^ (y[1] ? x2 : 8'h0) ^ (y[2] ? x4 : 8'h0) ^
               (y[3] ? x8 : 8'h0);
    endfunction

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            s[i] = in_data[127-8*i -: 8];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[4*c+r] = inv_sub_byte(s[4*((c+4-r)%4)+r]) ^
                           round_key[127-8*(4*c+r) -: 8];
            end
        end
        for (int c = 0; c < 4; c++) begin
            m[4*c]   = mul(t[4*c],4'he) ^ mul(t[4*c+1],4'hb) ^ mul(t[4*c+2],4'hd) ^
                       mul(t[4*c+3],4'h9);
            m[4*c+1] = mul(t[4*c],4'h9) ^ mul(t[4*c+1],4'he) ^ mul(t[4*c+2],4'hb) ^
                       mul(t[4*c+3],4'hd);
            m[4*c+2] = mul(t[4*c],4'hd) ^ mul(t[4*c+1],4'h9) ^ mul(t[4*c+2],4'he) ^
                       mul(t[4*c+3],4'hb);
            m[4*c+3] = mul(t[4*c],4'hb) ^ mul(t[4*c+1],4'hd) ^ mul(t[4*c+2],4'h9) ^
                       mul(t[4*c+3],4'he);
        end
        for (int i = 0; i < 16; i++) begin
            data_next[127-8*i -: 8] = LAST ? t[i] : m[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

// ----- rtl/aes_dec_key_sched.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aes_dec_key_sched
// key registers and round key expansion, one round key per cycle while it runs
// ----------------------------------------------------------------------------
module aes_dec_key_sched (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic               cfg_sel,
    input  wire logic [63:0]        cfg_data,
    output logic                    busy,
    output aes_dec_pkg::rkeys_t     round_keys
);
    import aes_dec_pkg::*;

    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    blk_t        rk_reg [NUM_ROUNDS+1];
    logic [3:0]  step_reg;
    logic        run_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= KEY_HIGH_RESET;
            key_low_reg  <= KEY_LOW_RESET;
            run_reg      <= 1'b1;
            step_reg     <= 4'd0;
        end else if (cfg_we) begin
            if (cfg_sel == CFG_KEY_HIGH) begin
                key_high_reg <= cfg_data;
            end else begin
                key_low_reg <= cfg_data;
            end
            run_reg  <= 1'b1;
            step_reg <= 4'd0;
        end else if (run_reg) begin
            if (step_reg == 4'(NUM_ROUNDS)) begin
                run_reg <= 1'b0;
            end else begin
                step_reg <= step_reg + 4'd1;
            end
        end
    end

    // step 0 loads the cipher key, each later step derives the next round key
    always_ff @(posedge aclk) begin
        if (run_reg && !cfg_we) begin
            for (int r = 0; r <= NUM_ROUNDS; r++) begin
                if (step_reg == 4'(r)) begin
                    if (r == 0) begin
                        rk_reg[r] <= {key_high_reg, key_low_reg};
                    end else begin
                        rk_reg[r] <= next_round_key(rk_reg[r-1], 4'(r-1));
                    end
                end
            end
        end
    end

    assign busy       = run_reg;
    assign round_keys = rk_reg;

endmodule
`default_nettype wire
